[rtl/crpl_pkg.sv]
// Package for the CIDR prefix region lookup: the entry record, operation and
// region codes, and the prefix mask helpers. Used by every file in rtl/.
`default_nettype none
package crpl_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_OPEN   = 2'd1,
      OP_ADD    = 2'd2,
      OP_CLOSE  = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   localparam logic [2:0] REGION_UNKNOWN = 3'd0;
   localparam logic [2:0] REGION_MAX     = 3'd4;
   localparam logic [7:0] V4_MAX_LEN     = 8'd32;
   localparam logic [7:0] V6_MAX_LEN     = 8'd128;

   typedef struct packed {
      logic        valid;
      logic        family;
      logic [7:0]  length;
      logic [2:0]  owner;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
   } entry_type;

   // Leading len bits set, len 0..32.
   function automatic logic [31:0] mask32(input logic [7:0] len);
      mask32 = ~(32'hFFFF_FFFF >> len);
   endfunction

   // Leading len bits set, len 0..128.
   function automatic logic [127:0] mask128(input logic [7:0] len);
      mask128 = ~({128{1'b1}} >> len);
   endfunction

endpackage
`default_nettype wire

[rtl/crpl_cell.sv]
// One prefix entry of the rotating table; passes its entry to the next cell
// each time the ring shifts. Depends on crpl_pkg.
`default_nettype none
module crpl_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift_en,
   input  wire crpl_pkg::entry_type entry_in,
   output crpl_pkg::entry_type     entry_out
);

   logic                valid_ff;
   crpl_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   always_comb begin
      entry_out       = entry_ff;
      entry_out.valid = valid_ff;
   end

endmodule
`default_nettype wire

[rtl/cidr_prefix_region_lookup.sv]
// Top level of the CIDR prefix region lookup: request and response streams,
// the sequencer, category state and the ring of crpl_cell entries.
// Depends on crpl_pkg and crpl_cell.
//
// Usage. Each request word on the req_ stream carries one operation: lookup,
// open category, add prefix or close category. Every request gives exactly
// one response word on the rsp_ stream with status, hit flag, hit category
// and region.
// The prefix entries sit in a ring of NUM_ENTRIES cells that rotates one
// place per cycle during a scan. Every operation makes one full turn of
// the ring, so the entry at the head in scan cycle k is entry k. A lookup
// records which categories own a matching entry, an open frees the entries
// of its category, and an add writes the lowest free entry passing the head.
// One request is in work at a time: it makes one full ring turn and then
// picks the first matching category. A new one is accepted once the
// previous result is in the output register, even while that response
// still waits there.
// Reset clears all entries' valid bits, all categories' region and loaded
// flags, and empties the output register. The table needs no clearing pass.
// When the receiver stalls, the response is held stable and the block waits
// with its finished result until the output register is free.
`default_nettype none
module cidr_prefix_region_lookup #(
   parameter int NUM_ENTRIES    = 256,
   parameter int NUM_CATEGORIES = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: category[2:0], region[5:3], addr_hi[69:6], addr_lo[133:70],
   //        prefix_len[141:134], zero fill[143:142]
   input  wire logic [143:0] req_tdata,
   // tuser: opcode[1:0], is_ipv6[2]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: status[1:0], hit[2], hit_category[5:3], result_region[8:6],
   //        zero fill[15:9]
   output logic [15:0]       rsp_tdata
);

   // Only eight categories can be addressed by the three-bit category field.
   localparam int NCAT  = (NUM_CATEGORIES < 8) ? NUM_CATEGORIES : 8;
   localparam int CAT_W = (NCAT > 1) ? $clog2(NCAT) : 1;
   localparam int IDX_W = $clog2(NUM_ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   // Request fields.
   logic [2:0]       req_category;
   logic [2:0]       req_region;
   logic [63:0]      req_addr_hi;
   logic [63:0]      req_addr_lo;
   logic [7:0]       req_prefix_len;
   crpl_pkg::op_type req_opcode;
   logic             req_is_ipv6;

   assign req_category   = req_tdata[2:0];
   assign req_region     = req_tdata[5:3];
   assign req_addr_hi    = req_tdata[69:6];
   assign req_addr_lo    = req_tdata[133:70];
   assign req_prefix_len = req_tdata[141:134];
   assign req_opcode     = crpl_pkg::op_type'(req_tuser[1:0]);
   assign req_is_ipv6    = req_tuser[2];

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   crpl_pkg::op_type op_ff;
   logic [2:0]       cat_ff, region_ff;
   logic             v6_ff, act_ff, rej_ff;
   logic [63:0]      hi_ff, lo_ff;
   logic [7:0]       plen_ff;
   logic             found_ff, found_in;
   logic [NCAT-1:0]  hitvec_ff, hitvec_in;
   logic [2:0]       cat_region_ff [NCAT];
   logic [NCAT-1:0]  cat_loaded_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [2:0]       rsp_cat_ff, rsp_cat_in, rsp_region_ff, rsp_region_in;

   logic req_fire, shift_en, last, rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign shift_en   = (state_ff == S_SCAN);
   assign last       = (cnt_ff == IDX_W'(NUM_ENTRIES - 1));
   assign rsp_load   = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   // Ring of entry cells; the head is cell 0 and it feeds back into the tail.
   crpl_pkg::entry_type ring [NUM_ENTRIES];
   crpl_pkg::entry_type head, head_new;

   assign head = ring[0];

   for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
      crpl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .entry_in  ((g == NUM_ENTRIES - 1) ? head_new : ring[(g + 1) % NUM_ENTRIES]),
         .entry_out (ring[g])
      );
   end

   // Head match against the request address, per family.
   logic [127:0] m128;
   logic [31:0]  m32;
   logic         head_match;

   always_comb begin
      m128 = crpl_pkg::mask128(head.length);
      m32  = crpl_pkg::mask32(head.length);
      if (v6_ff) begin
         head_match = (({hi_ff, lo_ff} & m128) == ({head.addr_hi, head.addr_lo} & m128));
      end else begin
         head_match = ((lo_ff[31:0] & m32) == (head.addr_lo[31:0] & m32));
      end
      head_match = head_match && head.valid && (head.family == v6_ff);
   end

   // Entry update at the head and per-category match collection.
   always_comb begin
      head_new  = head;
      found_in  = found_ff;
      hitvec_in = hitvec_ff;
      case (op_ff)
         crpl_pkg::OP_LOOKUP: begin
            if (head_match) begin
               hitvec_in[head.owner[CAT_W-1:0]] = 1'b1;
            end
         end
         crpl_pkg::OP_OPEN: begin
            if (act_ff && head.valid && head.owner == cat_ff) begin
               head_new.valid = 1'b0;
            end
         end
         crpl_pkg::OP_ADD: begin
            if (act_ff && !rej_ff && !found_ff && !head.valid) begin
               found_in         = 1'b1;
               head_new.valid   = 1'b1;
               head_new.family  = v6_ff;
               head_new.length  = plen_ff;
               head_new.owner   = cat_ff;
               head_new.addr_hi = v6_ff ? hi_ff : 64'd0;
               head_new.addr_lo = v6_ff ? lo_ff
                                        : {32'd0, lo_ff[31:0] & crpl_pkg::mask32(plen_ff)};
            end
         end
         default: begin
         end
      endcase
   end

   // Response status and lookup hit: first loaded matching category by index.
   always_comb begin
      rsp_status_in = crpl_pkg::ST_OK;
      rsp_hit_in    = 1'b0;
      rsp_cat_in    = 3'd0;
      rsp_region_in = crpl_pkg::REGION_UNKNOWN;
      if (op_ff == crpl_pkg::OP_LOOKUP) begin
         for (int c = NCAT - 1; c >= 0; c--) begin
            if (hitvec_ff[c] && cat_loaded_ff[c] &&
                (v6_ff || cat_region_ff[c] != crpl_pkg::REGION_UNKNOWN)) begin
               rsp_hit_in    = 1'b1;
               rsp_cat_in    = 3'(c);
               rsp_region_in = cat_region_ff[c];
            end
         end
      end else if (op_ff == crpl_pkg::OP_ADD && act_ff) begin
         if (rej_ff) begin
            rsp_status_in = crpl_pkg::ST_REJECTED;
         end else if (!found_ff) begin
            rsp_status_in = crpl_pkg::ST_FULL;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         hitvec_ff     <= '0;
         cat_loaded_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < NCAT; c++) begin
            cat_region_ff[c] <= crpl_pkg::REGION_UNKNOWN;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (req_fire) begin
            found_ff  <= 1'b0;
            hitvec_ff <= '0;
         end else if (shift_en) begin
            found_ff  <= found_in;
            hitvec_ff <= hitvec_in;
         end
         if (rsp_load && act_ff) begin
            if (op_ff == crpl_pkg::OP_OPEN) begin
               cat_region_ff[cat_ff[CAT_W-1:0]] <=
                  (region_ff > crpl_pkg::REGION_MAX) ? crpl_pkg::REGION_UNKNOWN : region_ff;
               cat_loaded_ff[cat_ff[CAT_W-1:0]] <= 1'b0;
            end else if (op_ff == crpl_pkg::OP_CLOSE) begin
               cat_loaded_ff[cat_ff[CAT_W-1:0]] <= 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_opcode;
         cat_ff    <= req_category;
         region_ff <= req_region;
         v6_ff     <= req_is_ipv6;
         hi_ff     <= req_addr_hi;
         lo_ff     <= req_addr_lo;
         plen_ff   <= req_prefix_len;
         act_ff    <= (32'(req_category) < NCAT);
         rej_ff    <= req_prefix_len >
                      (req_is_ipv6 ? crpl_pkg::V6_MAX_LEN : crpl_pkg::V4_MAX_LEN);
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_cat_ff    <= rsp_cat_in;
         rsp_region_ff <= rsp_region_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_region_ff, rsp_cat_ff, rsp_hit_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_SCAN |-> cnt_ff == '0)
      else $error("scan counter not at zero outside a scan");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_status_ff == crpl_pkg::ST_OK)
      else $error("hit reported together with a non-ok status");

   a_found_add: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |-> op_ff == crpl_pkg::OP_ADD)
      else $error("entry written by an operation other than add");

   a_hit_cat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> 32'(rsp_cat_ff) < NCAT)
      else $error("hit category out of range");
`endif

endmodule
`default_nettype wire
